FILE: rtl/core/sah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sah_pkg
// Shared types, codes and constants of the serial accessory handshake unit.
// ----------------------------------------------------------------------------
package sah_pkg;

	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_FRAME = 3'd1,
		KIND_KEY   = 3'd2,
		KIND_DATA  = 3'd3,
		KIND_WRITE = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		REG_LOGO_HASH   = 2'd0,
		REG_HOLD_TICKS  = 2'd1,
		REG_RUMBLE_CODE = 2'd2,
		REG_SERIAL_MTCH = 2'd3
	} reg_t;

	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [31:0] LOGO_HASH_RST   = 32'h7776eb55;
	localparam logic [9:0]  HOLD_TICKS_RST  = 10'd500;
	localparam logic [7:0]  RUMBLE_CODE_RST = 8'h26;
	localparam logic [16:0] SERIAL_MTCH_RST = 17'h1e000;

	localparam logic [4:0]  LAST_PACKET    = 5'd16;
	localparam logic [4:0]  RUMBLE_PACKET  = 5'd15;
	localparam logic [1:0]  LAST_PHASE     = 2'd2;
	localparam logic [1:0]  BAD_PHASE      = 2'd3;
	localparam logic [9:0]  KEY_IDLE       = 10'h3ff;
	localparam logic [9:0]  KEY_LOGO_PRESS = 10'h30f;

	// handshake word sent for each packet index
	function automatic logic [31:0] send_word_f(input logic [4:0] idx);
		logic [31:0] w;
		case (idx)
			5'd0:    w = 32'h0000494e;
			5'd1:    w = 32'hb6b1494e;
			5'd2:    w = 32'hb6b1494e;
			5'd3:    w = 32'hb6b1544e;
			5'd4:    w = 32'habb1544e;
			5'd5:    w = 32'habb14e45;
			5'd6:    w = 32'hb1ba4e45;
			5'd7:    w = 32'hb1ba4f44;
			5'd8:    w = 32'hb0bb4f44;
			5'd9:    w = 32'hb0bb8002;
			5'd10:   w = 32'h10000010;
			5'd11:   w = 32'h20000013;
			default: w = 32'h30000003;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/sah_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sah channel interfaces
// Valid/ready channels for event words into and result words out of the unit.
// ----------------------------------------------------------------------------
interface sah_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] frame_hash;
	logic [16:0] serial_setup;
	logic [1:0]  byte_lane;
	logic [7:0]  byte_value;

	modport source (output valid, kind, frame_hash, serial_setup, byte_lane, byte_value,
		input ready);
	modport sink (input valid, kind, frame_hash, serial_setup, byte_lane, byte_value,
		output ready);
endinterface

interface sah_result_if;
	logic        valid;
	logic        ready;
	logic        key_valid;
	logic [9:0]  key_value;
	logic        data_valid;
	logic [31:0] data_word;
	logic        rumble_valid;
	logic        rumble_level;
	logic        serial_irq;

	modport source (output valid, key_valid, key_value, data_valid, data_word,
		rumble_valid, rumble_level, serial_irq, input ready);
	modport sink (input valid, key_valid, key_value, data_valid, data_word,
		rumble_valid, rumble_level, serial_irq, output ready);
endinterface

FILE: rtl/core/serial_accessory_handshake_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_accessory_handshake_unit
// Accessory responder: logo detection, packet sequencing, key override,
// receive word assembly and rumble control with a tick-driven hold timer.
// ----------------------------------------------------------------------------
// The unit takes one event word per clock while its input stage can accept
// one and returns exactly one result word per event, in order. The update
// logic computes the new accessory state and result from the input stage
// register; both are written at the same edge, once the result register is
// free. Input and output registers are decoupled, so back-to-back words flow
// at one per cycle as long as results are taken; a stalled output holds one
// result while one more word waits in the input stage. The user writes the
// registers over the APB port only while idle; the unit does not enforce it.
module serial_accessory_handshake_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	sah_item_if.sink                     item,
	sah_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sah_pkg::PADDR_W-1:0]  paddr,
	input  logic [sah_pkg::PDATA_W-1:0]  pwdata,
	output logic [sah_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	// configuration registers
	logic [31:0] logo_hash_q;
	logic [9:0]  hold_ticks_q;
	logic [7:0]  rumble_code_q;
	logic [16:0] serial_match_q;

	// accessory state
	logic        enabled_q;
	logic        logo_seen_q;
	logic [1:0]  logo_phase_q;
	logic [4:0]  packet_index_q;
	logic [31:0] send_word_q;
	logic [31:0] recv_word_q;
	logic        rumble_on_q;
	logic [9:0]  hold_count_q;

	logic        enabled_n;
	logic        logo_seen_n;
	logic [1:0]  logo_phase_n;
	logic [4:0]  packet_index_n;
	logic [31:0] send_word_n;
	logic [31:0] recv_word_n;
	logic        rumble_on_n;
	logic [9:0]  hold_count_n;

	// input stage
	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [31:0] frame_hash_s1;
	logic [16:0] serial_setup_s1;
	logic [1:0]  byte_lane_s1;
	logic [7:0]  byte_value_s1;

	// result computed from the input stage
	logic        key_valid_c;
	logic [9:0]  key_value_c;
	logic        data_valid_c;
	logic [31:0] data_word_c;
	logic        rumble_valid_c;
	logic        rumble_level_c;
	logic        serial_irq_c;

	logic        out_valid_q;
	logic        advance;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	logic        logo_hit;
	logic [4:0]  packet_base;
	logic        rumble_hit;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign result.valid = out_valid_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		case (cfg_idx)
			sah_pkg::REG_LOGO_HASH:   prdata = logo_hash_q;
			sah_pkg::REG_HOLD_TICKS:  prdata = {22'd0, hold_ticks_q};
			sah_pkg::REG_RUMBLE_CODE: prdata = {24'd0, rumble_code_q};
			sah_pkg::REG_SERIAL_MTCH: prdata = {15'd0, serial_match_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logo_hash_q    <= sah_pkg::LOGO_HASH_RST;
			hold_ticks_q   <= sah_pkg::HOLD_TICKS_RST;
			rumble_code_q  <= sah_pkg::RUMBLE_CODE_RST;
			serial_match_q <= sah_pkg::SERIAL_MTCH_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				sah_pkg::REG_LOGO_HASH:   logo_hash_q    <= pwdata;
				sah_pkg::REG_HOLD_TICKS:  hold_ticks_q   <= pwdata[9:0];
				sah_pkg::REG_RUMBLE_CODE: rumble_code_q  <= pwdata[7:0];
				sah_pkg::REG_SERIAL_MTCH: serial_match_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1         <= item.kind;
			frame_hash_s1   <= item.frame_hash;
			serial_setup_s1 <= item.serial_setup;
			byte_lane_s1    <= item.byte_lane;
			byte_value_s1   <= item.byte_value;
		end
	end

	// ---------------- event update ----------------
	assign logo_hit    = (frame_hash_s1 == logo_hash_q);
	assign packet_base = logo_hit ? 5'd0 : packet_index_q;
	// lane 3 leaves the low byte alone, so the stored low byte decides
	assign rumble_hit  = (recv_word_q[7:0] == rumble_code_q);

	always_comb begin
		enabled_n      = enabled_q;
		logo_seen_n    = logo_seen_q;
		logo_phase_n   = logo_phase_q;
		packet_index_n = packet_index_q;
		send_word_n    = send_word_q;
		recv_word_n    = recv_word_q;
		rumble_on_n    = rumble_on_q;
		hold_count_n   = hold_count_q;
		key_valid_c    = 1'b0;
		key_value_c    = '0;
		data_valid_c   = 1'b0;
		data_word_c    = '0;
		rumble_valid_c = 1'b0;
		rumble_level_c = 1'b0;
		serial_irq_c   = 1'b0;

		case (kind_s1)
			sah_pkg::KIND_TICK: begin
				if (hold_count_q != 10'd0) begin
					hold_count_n = hold_count_q - 10'd1;
					if (hold_count_q == 10'd1) begin
						rumble_on_n    = 1'b0;
						rumble_valid_c = 1'b1;
					end
				end
			end
			sah_pkg::KIND_FRAME: begin
				logo_seen_n = logo_hit;
				if (logo_hit) begin
					enabled_n      = 1'b1;
					packet_index_n = 5'd0;
					case (logo_phase_q)
						sah_pkg::LAST_PHASE: logo_phase_n = 2'd0;
						sah_pkg::BAD_PHASE:  logo_phase_n = 2'd1;
						default:             logo_phase_n = logo_phase_q + 2'd1;
					endcase
				end
				if ((enabled_q || logo_hit) && serial_setup_s1 == serial_match_q) begin
					packet_index_n = (packet_base >= sah_pkg::LAST_PACKET) ? 5'd0
						: packet_base + 5'd1;
					send_word_n    = sah_pkg::send_word_f(packet_index_n);
					serial_irq_c   = 1'b1;
				end
			end
			sah_pkg::KIND_KEY: begin
				if (logo_seen_q && logo_phase_q != sah_pkg::BAD_PHASE) begin
					key_valid_c = 1'b1;
					key_value_c = (logo_phase_q == sah_pkg::LAST_PHASE)
						? sah_pkg::KEY_LOGO_PRESS : sah_pkg::KEY_IDLE;
				end
			end
			sah_pkg::KIND_DATA: begin
				if (enabled_q) begin
					data_valid_c = 1'b1;
					data_word_c  = send_word_q;
				end
			end
			sah_pkg::KIND_WRITE: begin
				if (enabled_q) begin
					case (byte_lane_s1)
						2'd0:    recv_word_n[7:0]   = byte_value_s1;
						2'd1:    recv_word_n[15:8]  = byte_value_s1;
						2'd2:    recv_word_n[23:16] = byte_value_s1;
						default: recv_word_n[31:24] = byte_value_s1;
					endcase
					if (byte_lane_s1 == 2'd3 && packet_index_q == sah_pkg::RUMBLE_PACKET) begin
						rumble_on_n    = rumble_hit;
						rumble_valid_c = 1'b1;
						rumble_level_c = rumble_hit;
						if (rumble_hit) begin
							hold_count_n = hold_ticks_q;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			logo_seen_q    <= 1'b0;
			logo_phase_q   <= 2'd0;
			packet_index_q <= 5'd0;
			send_word_q    <= '0;
			recv_word_q    <= '0;
			rumble_on_q    <= 1'b0;
			hold_count_q   <= '0;
		end else if (advance) begin
			enabled_q      <= enabled_n;
			logo_seen_q    <= logo_seen_n;
			logo_phase_q   <= logo_phase_n;
			packet_index_q <= packet_index_n;
			send_word_q    <= send_word_n;
			recv_word_q    <= recv_word_n;
			rumble_on_q    <= rumble_on_n;
			hold_count_q   <= hold_count_n;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.key_valid    <= key_valid_c;
			result.key_value    <= key_value_c;
			result.data_valid   <= data_valid_c;
			result.data_word    <= data_word_c;
			result.rumble_valid <= rumble_valid_c;
			result.rumble_level <= rumble_level_c;
			result.serial_irq   <= serial_irq_c;
		end
	end

	// ---------------- assertions ----------------
	a_irq_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.serial_irq |-> enabled_q)
		else $error("serial interrupt while accessory disabled");

	a_data_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data_valid |-> enabled_q)
		else $error("data answer while accessory disabled");

	a_packet_range: assert property (@(posedge clk) disable iff (!arst_n)
		packet_index_q <= sah_pkg::LAST_PACKET)
		else $error("packet index beyond last packet");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		logo_phase_q != sah_pkg::BAD_PHASE)
		else $error("logo phase reached unused code");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(valid_s1))
		else $error("result raised without a staged word");

endmodule
